### hw/rtl/ycc_pkg.sv
// ----------------------------------------------------------------------------
// ycc_pkg
// Shared constants, register indexes and types of the 4:2:0 YCbCr to RGB block.
// ----------------------------------------------------------------------------
package ycc_pkg;

    localparam int FRAC_BITS_DEF = 6;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 9;
    localparam int PROD_W    = 18;
    localparam int ACC_W     = 19;
    localparam int LANES     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CR_TO_RED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CR_TO_GREEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CB_TO_GREEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CB_TO_BLUE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_MODE = 3'd5;

    localparam logic [COEF_W-1:0] RST_LUMA_GAIN   = 8'd74;
    localparam logic [COEF_W-1:0] RST_CR_TO_RED   = 8'd102;
    localparam logic [COEF_W-1:0] RST_CR_TO_GREEN = 8'd52;
    localparam logic [COEF_W-1:0] RST_CB_TO_GREEN = 8'd25;
    localparam logic [COEF_W-1:0] RST_CB_TO_BLUE  = 8'd129;

    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd2;

    localparam logic signed [OP_W-1:0] LUMA_OFS   = 9'sd16;
    localparam logic signed [OP_W-1:0] CHROMA_OFS = 9'sd128;
    localparam logic [PIX_W-1:0]       PIX_MAX    = 8'd255;

    typedef struct packed {
        logic [COEF_W-1:0] luma_gain;
        logic [COEF_W-1:0] cr_to_red;
        logic [COEF_W-1:0] cr_to_green;
        logic [COEF_W-1:0] cb_to_green;
        logic [COEF_W-1:0] cb_to_blue;
    } coef_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

endpackage

### hw/rtl/ycc_upsample.sv
// ----------------------------------------------------------------------------
// ycc_upsample
// Chroma upsampling of one plane for the three non-anchor pixels of a block.
// ----------------------------------------------------------------------------
module ycc_upsample
    import ycc_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  logic [PIX_W-1:0]  here,
    input  logic [PIX_W-1:0]  right,
    input  logic [PIX_W-1:0]  below,
    input  logic [PIX_W-1:0]  diag,
    output logic [PIX_W-1:0]  top_right,
    output logic [PIX_W-1:0]  bottom_left,
    output logic [PIX_W-1:0]  bottom_right
);

    logic [PIX_W:0]   sum_tr;
    logic [PIX_W:0]   sum_bl;
    logic [PIX_W+1:0] sum_br;

    always_comb begin
        sum_tr = {1'b0, here} + {1'b0, right} + 9'd1;
        sum_bl = {1'b0, here} + {1'b0, below} + 9'd1;
        sum_br = {2'b00, here} + {2'b00, right} + {2'b00, below} + {2'b00, diag} + 10'd2;
        case (mode)
            MODE_ZERO: begin
                top_right    = '0;
                bottom_left  = '0;
                bottom_right = '0;
            end
            MODE_REPL: begin
                top_right    = here;
                bottom_left  = here;
                bottom_right = here;
            end
            default: begin
                top_right    = sum_tr[PIX_W:1];
                bottom_left  = sum_bl[PIX_W:1];
                bottom_right = sum_br[PIX_W+1:2];
            end
        endcase
    end

endmodule

### hw/rtl/ycc_lane.sv
// ----------------------------------------------------------------------------
// ycc_lane
// Color conversion of one pixel: registered products, then round, shift, clamp.
// ----------------------------------------------------------------------------
module ycc_lane
    import ycc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             load,
    input  logic [PIX_W-1:0] luma,
    input  logic [PIX_W-1:0] cb,
    input  logic [PIX_W-1:0] cr,
    input  coef_t            coef,
    output rgb_t             rgb
);

    localparam int HALF_I = 1 << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(HALF_I);

    logic signed [OP_W-1:0]   yb;
    logic signed [OP_W-1:0]   cbb;
    logic signed [OP_W-1:0]   crb;
    logic signed [PROD_W-1:0] yb_x;
    logic signed [PROD_W-1:0] cbb_x;
    logic signed [PROD_W-1:0] crb_x;

    logic signed [PROD_W-1:0] prod_y_next,  prod_y_reg;
    logic signed [PROD_W-1:0] prod_rr_next, prod_rr_reg;
    logic signed [PROD_W-1:0] prod_gr_next, prod_gr_reg;
    logic signed [PROD_W-1:0] prod_gb_next, prod_gb_reg;
    logic signed [PROD_W-1:0] prod_bb_next, prod_bb_reg;

    logic signed [ACC_W-1:0] acc_r;
    logic signed [ACC_W-1:0] acc_g;
    logic signed [ACC_W-1:0] acc_b;

    function automatic logic signed [PROD_W-1:0] widen_coef(input logic [COEF_W-1:0] c);
        return $signed({{(PROD_W-COEF_W){1'b0}}, c});
    endfunction

    function automatic logic signed [ACC_W-1:0] sext(input logic signed [PROD_W-1:0] p);
        return $signed({{(ACC_W-PROD_W){p[PROD_W-1]}}, p});
    endfunction

    function automatic logic [PIX_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> FRAC_BITS;
        if (acc[ACC_W-1]) begin
            return '0;
        end else if (sh > $signed({{(ACC_W-PIX_W){1'b0}}, PIX_MAX})) begin
            return PIX_MAX;
        end else begin
            return sh[PIX_W-1:0];
        end
    endfunction

    always_comb begin
        yb    = $signed({1'b0, luma}) - LUMA_OFS;
        cbb   = $signed({1'b0, cb}) - CHROMA_OFS;
        crb   = $signed({1'b0, cr}) - CHROMA_OFS;
        yb_x  = $signed({{(PROD_W-OP_W){yb[OP_W-1]}}, yb});
        cbb_x = $signed({{(PROD_W-OP_W){cbb[OP_W-1]}}, cbb});
        crb_x = $signed({{(PROD_W-OP_W){crb[OP_W-1]}}, crb});
        prod_y_next  = widen_coef(coef.luma_gain) * yb_x;
        prod_rr_next = widen_coef(coef.cr_to_red) * crb_x;
        prod_gr_next = widen_coef(coef.cr_to_green) * crb_x;
        prod_gb_next = widen_coef(coef.cb_to_green) * cbb_x;
        prod_bb_next = widen_coef(coef.cb_to_blue) * cbb_x;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_y_reg  <= prod_y_next;
            prod_rr_reg <= prod_rr_next;
            prod_gr_reg <= prod_gr_next;
            prod_gb_reg <= prod_gb_next;
            prod_bb_reg <= prod_bb_next;
        end
    end

    always_comb begin
        acc_r = sext(prod_y_reg) + sext(prod_rr_reg) + HALF;
        acc_g = sext(prod_y_reg) - sext(prod_gr_reg) - sext(prod_gb_reg) + HALF;
        acc_b = sext(prod_y_reg) + sext(prod_bb_reg) + HALF;
        rgb.red   = finish(acc_r);
        rgb.green = finish(acc_g);
        rgb.blue  = finish(acc_b);
    end

endmodule

### hw/rtl/ycbcr420_to_rgb_block.sv
// ----------------------------------------------------------------------------
// ycbcr420_to_rgb_block
// BT.601 YCbCr 4:2:0 to RGB conversion of one 2x2 pixel block per beat.
//
// The s_ channel carries four luma samples and the 2x2 Cb and Cr neighborhood
// of the block; the m_ channel returns the clamped RGB of the four pixels.
// The cfg_ channel writes the five coefficients (index 0..4) and the chroma
// upsampling mode (index 5); other indexes are dropped. Write only while idle.
// Four conversion lanes, one per pixel, run side by side; an output register
// merges them into one result beat.
// A block passes the chroma, product and output registers. Throughput: one block
// per clock while m_ready holds, set by the three register stages, each of which
// advances whenever the stage after it is empty or moving.
// Reset loads the default coefficients and mode 2 and empties the pipeline.
// When the receiver stalls, the stages fill up; s_ready drops only after
// three beats are held inside.
// ----------------------------------------------------------------------------
module ycbcr420_to_rgb_block
    import ycc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_luma_tl,
    input  logic [PIX_W-1:0]     s_luma_tr,
    input  logic [PIX_W-1:0]     s_luma_bl,
    input  logic [PIX_W-1:0]     s_luma_br,
    input  logic [PIX_W-1:0]     s_blue_diff_here,
    input  logic [PIX_W-1:0]     s_blue_diff_right,
    input  logic [PIX_W-1:0]     s_blue_diff_below,
    input  logic [PIX_W-1:0]     s_blue_diff_diag,
    input  logic [PIX_W-1:0]     s_red_diff_here,
    input  logic [PIX_W-1:0]     s_red_diff_right,
    input  logic [PIX_W-1:0]     s_red_diff_below,
    input  logic [PIX_W-1:0]     s_red_diff_diag,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_red_tl,
    output logic [PIX_W-1:0]     m_green_tl,
    output logic [PIX_W-1:0]     m_blue_tl,
    output logic [PIX_W-1:0]     m_red_tr,
    output logic [PIX_W-1:0]     m_green_tr,
    output logic [PIX_W-1:0]     m_blue_tr,
    output logic [PIX_W-1:0]     m_red_bl,
    output logic [PIX_W-1:0]     m_green_bl,
    output logic [PIX_W-1:0]     m_blue_bl,
    output logic [PIX_W-1:0]     m_red_br,
    output logic [PIX_W-1:0]     m_green_br,
    output logic [PIX_W-1:0]     m_blue_br,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    coef_t             coef_reg, coef_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic vo_reg, vo_next;
    logic rdy1, rdy2, rdy_o;

    logic [PIX_W-1:0] luma_s1_reg [LANES];
    logic [PIX_W-1:0] cb_s1_reg   [LANES];
    logic [PIX_W-1:0] cr_s1_reg   [LANES];

    logic [PIX_W-1:0] cb_tr, cb_bl, cb_br;
    logic [PIX_W-1:0] cr_tr, cr_bl, cr_br;

    rgb_t lane_rgb    [LANES];
    rgb_t rgb_out_reg [LANES];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        coef_next = coef_reg;
        mode_next = mode_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_LUMA_GAIN:     coef_next.luma_gain   = cfg_data;
                REG_CR_TO_RED:     coef_next.cr_to_red   = cfg_data;
                REG_CR_TO_GREEN:   coef_next.cr_to_green = cfg_data;
                REG_CB_TO_GREEN:   coef_next.cb_to_green = cfg_data;
                REG_CB_TO_BLUE:    coef_next.cb_to_blue  = cfg_data;
                REG_UPSAMPLE_MODE: mode_next             = cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.luma_gain   <= RST_LUMA_GAIN;
            coef_reg.cr_to_red   <= RST_CR_TO_RED;
            coef_reg.cr_to_green <= RST_CR_TO_GREEN;
            coef_reg.cb_to_green <= RST_CB_TO_GREEN;
            coef_reg.cb_to_blue  <= RST_CB_TO_BLUE;
            mode_reg             <= MODE_AVG;
        end else begin
            coef_reg <= coef_next;
            mode_reg <= mode_next;
        end
    end

    // pipeline flow control
    always_comb begin
        rdy_o   = !vo_reg || m_ready;
        rdy2    = !v2_reg || rdy_o;
        rdy1    = !v1_reg || rdy2;
        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        vo_next = rdy_o ? v2_reg : vo_reg;
    end

    assign s_ready = rdy1;
    assign m_valid = vo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    // chroma upsampling stage
    ycc_upsample u_up_cb (
        .mode         (mode_reg),
        .here         (s_blue_diff_here),
        .right        (s_blue_diff_right),
        .below        (s_blue_diff_below),
        .diag         (s_blue_diff_diag),
        .top_right    (cb_tr),
        .bottom_left  (cb_bl),
        .bottom_right (cb_br)
    );

    ycc_upsample u_up_cr (
        .mode         (mode_reg),
        .here         (s_red_diff_here),
        .right        (s_red_diff_right),
        .below        (s_red_diff_below),
        .diag         (s_red_diff_diag),
        .top_right    (cr_tr),
        .bottom_left  (cr_bl),
        .bottom_right (cr_br)
    );

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            luma_s1_reg[0] <= s_luma_tl;
            luma_s1_reg[1] <= s_luma_tr;
            luma_s1_reg[2] <= s_luma_bl;
            luma_s1_reg[3] <= s_luma_br;
            cb_s1_reg[0]   <= s_blue_diff_here;
            cb_s1_reg[1]   <= cb_tr;
            cb_s1_reg[2]   <= cb_bl;
            cb_s1_reg[3]   <= cb_br;
            cr_s1_reg[0]   <= s_red_diff_here;
            cr_s1_reg[1]   <= cr_tr;
            cr_s1_reg[2]   <= cr_bl;
            cr_s1_reg[3]   <= cr_br;
        end
    end

    // conversion lanes
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        ycc_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk (aclk),
            .load (rdy2),
            .luma (luma_s1_reg[i]),
            .cb   (cb_s1_reg[i]),
            .cr   (cr_s1_reg[i]),
            .coef (coef_reg),
            .rgb  (lane_rgb[i])
        );
    end

    // merge lanes into the result beat
    always_ff @(posedge aclk) begin
        if (rdy_o) begin
            for (int i = 0; i < LANES; i++) begin
                rgb_out_reg[i] <= lane_rgb[i];
            end
        end
    end

    assign m_red_tl   = rgb_out_reg[0].red;
    assign m_green_tl = rgb_out_reg[0].green;
    assign m_blue_tl  = rgb_out_reg[0].blue;
    assign m_red_tr   = rgb_out_reg[1].red;
    assign m_green_tr = rgb_out_reg[1].green;
    assign m_blue_tr  = rgb_out_reg[1].blue;
    assign m_red_bl   = rgb_out_reg[2].red;
    assign m_green_bl = rgb_out_reg[2].green;
    assign m_blue_bl  = rgb_out_reg[2].blue;
    assign m_red_br   = rgb_out_reg[3].red;
    assign m_green_br = rgb_out_reg[3].green;
    assign m_blue_br  = rgb_out_reg[3].blue;

    a_accept_fills_stage1 : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted beat not held in chroma stage");

    a_stage2_reaches_output : assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && rdy_o |=> m_valid)
        else $error("product stage beat lost before output");

    a_mode_write : assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index == REG_UPSAMPLE_MODE
            |=> mode_reg == $past(cfg_data[MODE_W-1:0]))
        else $error("upsample mode write not taken");

    a_full_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && vo_reg && !m_ready |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

endmodule
